### rtl/assert_macros.svh
// Assertion macros for the checker file of this block.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define P_ASSERT_IMPL(name, clk_s, rst_s, ante, cons) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset
`define P_ASSERT_NEXT(name, clk_s, rst_s, ante, cons) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("assertion failed");

// Next-cycle implication that also holds across reset
`define P_ASSERT_NEXT_ALWAYS(name, clk_s, ante, cons) \
  name: assert property (@(posedge clk_s) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### rtl/p1305_pkg.sv
// Shared types and constants for the Poly1305 MAC engine.
// No dependencies.
package p1305_pkg;

  localparam int KEY_W   = 128;
  localparam int HALF_W  = 64;
  localparam int LEN_W   = 5;
  localparam int ACC_W   = 130;
  localparam int H_W     = 131;
  localparam int LIMB_W  = 32;
  localparam int X_W     = 288;
  localparam int FOLD_W  = 132;
  localparam int IDX_W   = 2;

  // Item kinds carried in tuser
  localparam logic OP_ABSORB = 1'b0;
  localparam logic OP_DIGEST = 1'b1;

  // Register indexes
  localparam logic [IDX_W-1:0] REG_R_LOW  = 2'd0;
  localparam logic [IDX_W-1:0] REG_R_HIGH = 2'd1;
  localparam logic [IDX_W-1:0] REG_S_LOW  = 2'd2;
  localparam logic [IDX_W-1:0] REG_S_HIGH = 2'd3;

  // Standard r clamp mask
  localparam logic [KEY_W-1:0] CLAMP_MASK = 128'h0ffffffc0ffffffc0ffffffc0fffffff;

  // Largest block length in bytes
  localparam logic [LEN_W-1:0] MAX_LEN = 5'd16;

  // Datapath commands from the controller
  typedef struct packed {
    logic       load;    // absorb start: h = acc + padded block, clear product
    logic       mac;     // one 32x32 partial product
    logic [2:0] mac_i;   // accumulator limb
    logic [1:0] mac_j;   // r limb
    logic       fold;    // x = x mod 2^130 + 5 * (x >> 130)
    logic       reduce;  // final conditional subtraction of p, write acc
    logic       digest;  // tag = acc + s, clear acc
  } p1305_cmd_t;

endpackage

### rtl/p1305_keys.sv
// Key register file: r and s halves written through the config port.
// Depends on p1305_pkg.
module p1305_keys (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [p1305_pkg::IDX_W-1:0]   cfg_index,
  input  logic [p1305_pkg::HALF_W-1:0]  cfg_wdata,
  output logic [p1305_pkg::KEY_W-1:0]   r_key,
  output logic [p1305_pkg::KEY_W-1:0]   s_key
);
  import p1305_pkg::*;

  logic [HALF_W-1:0] r_low, r_high, s_low, s_high;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      r_low  <= '0;
      r_high <= '0;
      s_low  <= '0;
      s_high <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_R_LOW:  r_low  <= cfg_wdata;
        REG_R_HIGH: r_high <= cfg_wdata;
        REG_S_LOW:  s_low  <= cfg_wdata;
        REG_S_HIGH: s_high <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // r is clamped on the way out
  assign r_key = {r_high, r_low} & CLAMP_MASK;
  assign s_key = {s_high, s_low};

endmodule

### rtl/p1305_ctrl.sv
// Controller: sequences block absorb (load, 20 partial products, two folds,
// final reduction) and digest; owns the handshakes. Depends on p1305_pkg.
module p1305_ctrl (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    s_tvalid,
  input  logic                    s_op,
  output logic                    s_tready,
  output logic                    m_tvalid,
  input  logic                    m_tready,
  output p1305_pkg::p1305_cmd_t   cmd
);
  import p1305_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_MAC    = 3'd1;
  localparam logic [2:0] ST_FOLD1  = 3'd2;
  localparam logic [2:0] ST_FOLD2  = 3'd3;
  localparam logic [2:0] ST_FINAL  = 3'd4;
  localparam logic [2:0] ST_DIGEST = 3'd5;

  localparam logic [2:0] LAST_I = 3'd4;
  localparam logic [1:0] LAST_J = 2'd3;

  logic [2:0] state, state_next;
  logic [2:0] cnt_i, cnt_i_next;
  logic [1:0] cnt_j, cnt_j_next;
  logic       accept;
  logic       out_free;

  assign s_tready = (state == ST_IDLE) && !rst;
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  // Next state and commands
  always_comb begin
    state_next = state;
    cnt_i_next = cnt_i;
    cnt_j_next = cnt_j;
    cmd        = '0;
    cmd.mac_i  = cnt_i;
    cmd.mac_j  = cnt_j;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          cnt_i_next = '0;
          cnt_j_next = '0;
          if (s_op == OP_DIGEST) begin
            state_next = ST_DIGEST;
          end else begin
            cmd.load   = 1'b1;
            state_next = ST_MAC;
          end
        end
      end
      ST_MAC: begin
        cmd.mac    = 1'b1;
        cnt_j_next = cnt_j + 2'd1;
        if (cnt_j == LAST_J) begin
          cnt_i_next = cnt_i + 3'd1;
          if (cnt_i == LAST_I) state_next = ST_FOLD1;
        end
      end
      ST_FOLD1: begin
        cmd.fold   = 1'b1;
        state_next = ST_FOLD2;
      end
      ST_FOLD2: begin
        cmd.fold   = 1'b1;
        state_next = ST_FINAL;
      end
      ST_FINAL: begin
        cmd.reduce = 1'b1;
        state_next = ST_IDLE;
      end
      ST_DIGEST: begin
        if (out_free) begin
          cmd.digest = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // State and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt_i <= '0;
      cnt_j <= '0;
    end else begin
      state <= state_next;
      cnt_i <= cnt_i_next;
      cnt_j <= cnt_j_next;
    end
  end

  // Output valid: set by a digest, cleared when the tag is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.digest) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

endmodule

### rtl/p1305_dp.sv
// Datapath: accumulator, block padding, 32x32 multiply-accumulate over a
// 288-bit product register, fold and final reduction, tag register.
// Depends on p1305_pkg.
module p1305_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  p1305_pkg::p1305_cmd_t         cmd,
  input  logic [p1305_pkg::HALF_W-1:0]  block_low,
  input  logic [p1305_pkg::HALF_W-1:0]  block_high,
  input  logic [p1305_pkg::LEN_W-1:0]   block_len,
  input  logic [p1305_pkg::KEY_W-1:0]   r_key,
  input  logic [p1305_pkg::KEY_W-1:0]   s_key,
  output logic [p1305_pkg::KEY_W-1:0]   tag
);
  import p1305_pkg::*;

  logic [ACC_W-1:0]  acc_q;
  logic [H_W-1:0]    h_q;
  logic [X_W-1:0]    x_q;
  logic [LIMB_W-1:0] c_q;

  logic [LEN_W-1:0]  len_sat;
  logic [KEY_W-1:0]  keep_mask;
  logic [KEY_W:0]    pad;
  logic [KEY_W:0]    blk_val;
  logic [H_W-1:0]    h_sum;

  logic [159:0]       h_ext;
  logic [LIMB_W-1:0]  h_limb, r_limb, x_limb, carry_in;
  logic [3:0]         x_idx, x_top_idx;
  logic [63:0]        mac_sum;
  logic [X_W-1:0]     x_mac;

  logic [125:0]       fold_hi;
  logic [FOLD_W-1:0]  fold_sum;
  logic [FOLD_W-1:0]  g_sum;

  // Byte mask and 0x01 pad byte after the last message byte
  always_comb begin
    len_sat   = (block_len > MAX_LEN) ? MAX_LEN : block_len;
    keep_mask = '0;
    pad       = '0;
    for (int k = 0; k < 16; k++) begin
      keep_mask[8*k +: 8] = (5'(k) < len_sat) ? 8'hff : 8'h00;
    end
    for (int k = 0; k <= 16; k++) begin
      pad[8*k] = (len_sat == 5'(k));
    end
    blk_val = {1'b0, {block_high, block_low} & keep_mask} | pad;
    h_sum   = {1'b0, acc_q} + {2'b0, blk_val};
  end

  // One partial product: x[i+j] + h[i]*r[j] + carry
  always_comb begin
    h_ext     = {29'b0, h_q};
    h_limb    = h_ext[{cmd.mac_i, 5'b0} +: LIMB_W];
    r_limb    = r_key[{cmd.mac_j, 5'b0} +: LIMB_W];
    x_idx     = {1'b0, cmd.mac_i} + {2'b0, cmd.mac_j};
    x_top_idx = {1'b0, cmd.mac_i} + 4'd4;
    x_limb    = x_q[{x_idx, 5'b0} +: LIMB_W];
    carry_in  = (cmd.mac_j == 2'd0) ? '0 : c_q;
    mac_sum   = (64'(h_limb) * 64'(r_limb)) + {32'b0, x_limb} + {32'b0, carry_in};
    // product register with this step's limb, and the row carry on the last r limb
    x_mac     = x_q;
    x_mac[{x_idx, 5'b0} +: LIMB_W] = mac_sum[31:0];
    if (cmd.mac_j == 2'd3) x_mac[{x_top_idx, 5'b0} +: LIMB_W] = mac_sum[63:32];
  end

  // Fold bits above 2^130 back in times five; final subtract of p
  always_comb begin
    fold_hi  = x_q[255:130];
    fold_sum = {2'b0, x_q[129:0]} + {4'b0, fold_hi, 2'b0} + {6'b0, fold_hi};
    g_sum    = x_q[FOLD_W-1:0] + 132'd5;
  end

  // Accumulator (state, cleared by reset)
  always_ff @(posedge clk) begin
    if (rst) begin
      acc_q <= '0;
    end else if (cmd.reduce) begin
      acc_q <= (g_sum[131:130] != 2'b00) ? g_sum[129:0] : x_q[129:0];
    end else if (cmd.digest) begin
      acc_q <= '0;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      h_q <= h_sum;
      x_q <= '0;
    end else if (cmd.mac) begin
      x_q <= x_mac;
      c_q <= mac_sum[63:32];
    end else if (cmd.fold) begin
      x_q <= {156'b0, fold_sum};
    end
  end

  // Tag register
  always_ff @(posedge clk) begin
    if (cmd.digest) tag <= acc_q[KEY_W-1:0] + s_key;
  end

endmodule

### rtl/poly1305_mac_engine.sv
// Poly1305 MAC engine. Absorb item: 1 load, 20 serial 32x32 partial products,
// 2 folds, 1 reduction, run on the single shared multiplier; no new item
// is taken until the reduction is done. Digest item: the digest state issues
// the digest once the tag register is free, and tag and valid are registered;
// the next item follows. Synchronous reset clears keys, accumulator and valids.
// Depends on p1305_pkg, p1305_keys, p1305_ctrl, p1305_dp.
module poly1305_mac_engine (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [135:0]                  s_tdata,   // block_low, block_high, block_len, pad
  input  logic                          s_tuser,   // op
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [127:0]                  m_tdata,   // tag_low, tag_high
  input  logic                          cfg_we,
  input  logic [p1305_pkg::IDX_W-1:0]   cfg_index,
  input  logic [p1305_pkg::HALF_W-1:0]  cfg_wdata
);
  import p1305_pkg::*;

  p1305_cmd_t        cmd;
  logic [KEY_W-1:0]  r_key, s_key;

  p1305_keys u_keys (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .r_key     (r_key),
    .s_key     (s_key)
  );

  p1305_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_op     (s_tuser),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd)
  );

  p1305_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .block_low  (s_tdata[63:0]),
    .block_high (s_tdata[127:64]),
    .block_len  (s_tdata[132:128]),
    .r_key      (r_key),
    .s_key      (s_key),
    .tag        (m_tdata)
  );

endmodule

### rtl/p1305_checker.sv
// Port-level checker for the Poly1305 MAC engine, bound to the top level.
// Depends on assert_macros.svh.
module p1305_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [127:0] m_tdata
);
`include "assert_macros.svh"

  // A stalled tag stays valid and unchanged
  `P_ASSERT_NEXT(a_hold_valid, clk, rst, m_tvalid && !m_tready, m_tvalid)
  `P_ASSERT_NEXT(a_hold_data, clk, rst, m_tvalid && !m_tready, $stable(m_tdata))

  // Every accepted item keeps the engine busy for at least the next cycle
  `P_ASSERT_NEXT(a_busy_after_accept, clk, rst, s_tvalid && s_tready, !s_tready)

  // No tag is pending right after reset
  `P_ASSERT_NEXT_ALWAYS(a_reset_clears, clk, rst, !m_tvalid)

endmodule

bind poly1305_mac_engine p1305_checker u_chk (.*);
